### hw/rtl/arf_pkg.sv
// shared types and constants of the arma residual filter
`default_nettype none

package arf_pkg;

    // field widths
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 5;
    localparam int COEF_W      = 24;
    localparam int DATA_W      = 32;
    localparam int AR_ORDER_W  = 5;
    localparam int MA_ORDER_W  = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = COEF_W + DATA_W;
    localparam int ACC_W       = 64;
    localparam int FRAC_SHIFT  = 20;

    // stream packing
    localparam int COEF_IDX_LSB = 0;
    localparam int COEF_VAL_LSB = COEF_IDX_LSB + IDX_W;
    localparam int SAMPLE_LSB   = COEF_VAL_LSB + COEF_W;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 32;

    localparam logic signed [ACC_W-1:0]  ROUND_HALF = 64'sh0000_0000_0008_0000;
    localparam logic signed [DATA_W-1:0] SAT_POS    = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_NEG    = 32'sh8000_0000;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD_AR = 2'd0,
        KIND_LOAD_MA = 2'd1,
        KIND_SAMPLE  = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_AR_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MA_ORDER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 2'd2;

    typedef struct packed {
        logic ar_wr;
        logic ma_wr;
        logic clear;
        logic start;
        logic mac_ar;
        logic mac_ma;
        logic compute;
        logic push;
        logic out_load;
    } arf_cmd_t;

    typedef struct packed {
        logic emit;
    } arf_status_t;

endpackage

`default_nettype wire

### hw/rtl/arf_ctrl.sv
// sequencer of the arma residual filter: item decode, tap stepping, result handshake
`default_nettype none

module arf_ctrl #(
    parameter int MAX_AR = 20,
    parameter int MAX_MA = 5,
    parameter int STW    = 5
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [arf_pkg::KIND_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    input  wire arf_pkg::arf_status_t      status,
    output arf_pkg::arf_cmd_t              cmd,
    output logic [STW-1:0]                 tap_idx
);
    import arf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AR,
        ST_MA,
        ST_DRAIN,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t         state_reg;
    logic [STW-1:0] step_reg;
    logic           m_tvalid_reg;
    kind_t          kind;
    logic           accept;
    logic           out_free;

    assign kind     = kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign tap_idx  = step_reg;

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (kind)
                        KIND_LOAD_AR: cmd.ar_wr = 1'b1;
                        KIND_LOAD_MA: cmd.ma_wr = 1'b1;
                        KIND_SAMPLE:  cmd.start = 1'b1;
                        KIND_RESTART: cmd.clear = 1'b1;
                        default:      cmd = '0;
                    endcase
                end
            end
            ST_AR:    cmd.mac_ar = 1'b1;
            ST_MA:    cmd.mac_ma = 1'b1;
            ST_ROUND: cmd.compute = 1'b1;
            ST_FINISH: begin
                // a result waits here until the output register is free
                if (!status.emit || out_free) begin
                    cmd.push     = 1'b1;
                    cmd.out_load = status.emit;
                end
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    step_reg <= '0;
                    if (cmd.start) begin
                        state_reg <= status.emit ? ST_AR : ST_FINISH;
                    end
                end
                ST_AR: begin
                    if (step_reg == STW'(MAX_AR - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_MA;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_MA: begin
                    if (step_reg == STW'(MAX_MA - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_DRAIN;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DRAIN: state_reg <= ST_ROUND;
                ST_ROUND: state_reg <= ST_FINISH;
                ST_FINISH: begin
                    if (cmd.push) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/arf_datapath.sv
// coefficient tables, histories, shared multiply-accumulate and residual rounding
`default_nettype none

module arf_datapath #(
    parameter int MAX_AR = 20,
    parameter int MAX_MA = 5,
    parameter int STW    = 5
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire arf_pkg::arf_cmd_t                   cmd,
    input  wire logic [STW-1:0]                      tap_idx,
    input  wire logic                                cfg_wr_en,
    input  wire logic [arf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [arf_pkg::DATA_W-1:0]          cfg_wdata,
    input  wire logic [arf_pkg::IDX_W-1:0]           coef_index,
    input  wire logic signed [arf_pkg::COEF_W-1:0]   coef_value,
    input  wire logic signed [arf_pkg::DATA_W-1:0]   sample,
    output arf_pkg::arf_status_t                     status,
    output logic signed [arf_pkg::DATA_W-1:0]        residual,
    output logic                                     saturated
);
    import arf_pkg::*;

    localparam int MAXP = (MAX_AR > MAX_MA) ? MAX_AR : MAX_MA;
    localparam int CW   = (STW > IDX_W) ? STW : IDX_W;
    localparam int AIW  = (MAX_AR > 1) ? $clog2(MAX_AR) : 1;
    localparam int MIW  = (MAX_MA > 1) ? $clog2(MAX_MA) : 1;
    localparam int TOPW = ACC_W - FRAC_SHIFT - DATA_W + 1;

    logic [AR_ORDER_W-1:0]     ar_order_reg;
    logic [MA_ORDER_W-1:0]     ma_order_reg;
    logic signed [DATA_W-1:0]  intercept_reg;

    logic signed [COEF_W-1:0]  ar_tab_reg [MAX_AR];
    logic signed [COEF_W-1:0]  ma_tab_reg [MAX_MA];
    logic signed [DATA_W-1:0]  sh_reg     [MAX_AR];
    logic signed [DATA_W-1:0]  rh_reg     [MAX_MA];
    logic [STW-1:0]            seen_reg;

    logic signed [DATA_W-1:0]  x_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_vld_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   y_reg;
    logic signed [DATA_W-1:0]  res_out_reg;
    logic                      sat_out_reg;

    logic [CW-1:0]             p_eff;
    logic [CW-1:0]             q_eff;
    logic                      ar_use;
    logic                      ma_use;
    logic                      ar_slot_ok;
    logic                      ma_slot_ok;
    logic signed [COEF_W-1:0]  op_a;
    logic signed [DATA_W-1:0]  op_b;
    logic signed [PROD_W-1:0]  prod_calc;
    logic [TOPW-1:0]           y_top;
    logic                      ovf;
    logic signed [DATA_W-1:0]  res_sat;
    logic signed [DATA_W-1:0]  res_push;

    // orders above the table depth act as the depth
    assign p_eff = (CW'(ar_order_reg) > CW'(MAX_AR)) ? CW'(MAX_AR) : CW'(ar_order_reg);
    assign q_eff = (CW'(ma_order_reg) > CW'(MAX_MA)) ? CW'(MAX_MA) : CW'(ma_order_reg);
    assign status.emit = (CW'(seen_reg) >= p_eff) && (CW'(seen_reg) >= q_eff);

    assign ar_use     = CW'(tap_idx) < p_eff;
    assign ma_use     = CW'(tap_idx) < q_eff;
    assign ar_slot_ok = CW'(coef_index) < CW'(MAX_AR);
    assign ma_slot_ok = CW'(coef_index) < CW'(MAX_MA);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ar_order_reg  <= '0;
            ma_order_reg  <= '0;
            intercept_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_AR_ORDER:  ar_order_reg  <= cfg_wdata[AR_ORDER_W-1:0];
                CFG_MA_ORDER:  ma_order_reg  <= cfg_wdata[MA_ORDER_W-1:0];
                CFG_INTERCEPT: intercept_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // coefficient tables rotate one slot per tap step, back in place after a full phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_AR; i++) ar_tab_reg[i] <= '0;
            for (int j = 0; j < MAX_MA; j++) ma_tab_reg[j] <= '0;
        end else begin
            if (cmd.ar_wr && ar_slot_ok) begin
                ar_tab_reg[AIW'(coef_index)] <= coef_value;
            end else if (cmd.mac_ar) begin
                for (int i = 0; i < MAX_AR; i++) ar_tab_reg[i] <= ar_tab_reg[(i + 1) % MAX_AR];
            end
            if (cmd.ma_wr && ma_slot_ok) begin
                ma_tab_reg[MIW'(coef_index)] <= coef_value;
            end else if (cmd.mac_ma) begin
                for (int j = 0; j < MAX_MA; j++) ma_tab_reg[j] <= ma_tab_reg[(j + 1) % MAX_MA];
            end
        end
    end

    // sample and residual histories, entry 0 most recent
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int i = 0; i < MAX_AR; i++) sh_reg[i] <= '0;
            for (int j = 0; j < MAX_MA; j++) rh_reg[j] <= '0;
            seen_reg <= '0;
        end else if (cmd.push) begin
            sh_reg[0] <= x_reg;
            for (int i = 1; i < MAX_AR; i++) sh_reg[i] <= sh_reg[i-1];
            rh_reg[0] <= res_push;
            for (int j = 1; j < MAX_MA; j++) rh_reg[j] <= rh_reg[j-1];
            if (seen_reg < STW'(MAXP)) begin
                seen_reg <= seen_reg + 1'b1;
            end
        end else begin
            if (cmd.mac_ar) begin
                for (int i = 0; i < MAX_AR; i++) sh_reg[i] <= sh_reg[(i + 1) % MAX_AR];
            end
            if (cmd.mac_ma) begin
                for (int j = 0; j < MAX_MA; j++) rh_reg[j] <= rh_reg[(j + 1) % MAX_MA];
            end
        end
    end

    // shared multiplier, product registered before the accumulator
    assign op_a      = cmd.mac_ar ? ar_tab_reg[0] : ma_tab_reg[0];
    assign op_b      = cmd.mac_ar ? sh_reg[0] : rh_reg[0];
    assign prod_calc = op_a * op_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mac_ar || cmd.mac_ma;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mac_ar || cmd.mac_ma) begin
            prod_reg <= (cmd.mac_ar ? ar_use : ma_use) ? prod_calc : '0;
        end
        if (cmd.start) begin
            x_reg   <= sample;
            // rounding half folded into the starting value
            acc_reg <= (ACC_W'(intercept_reg) <<< FRAC_SHIFT) - ROUND_HALF;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.compute) begin
            y_reg <= (ACC_W'(x_reg) <<< FRAC_SHIFT) - acc_reg;
        end
        if (cmd.out_load) begin
            res_out_reg <= res_sat;
            sat_out_reg <= ovf;
        end
    end

    // floor shift by the fraction width, then clip to 32 bits
    assign y_top    = y_reg[ACC_W-1:FRAC_SHIFT+DATA_W-1];
    assign ovf      = (y_top != '0) && (y_top != '1);
    assign res_sat  = ovf ? (y_reg[ACC_W-1] ? SAT_NEG : SAT_POS)
                          : y_reg[FRAC_SHIFT+DATA_W-1:FRAC_SHIFT];
    assign res_push = status.emit ? res_sat : '0;

    assign residual  = res_out_reg;
    assign saturated = sat_out_reg;

endmodule

`default_nettype wire

### hw/rtl/arma_residual_filter_core.sv
// top level of the streaming arma inverse filter
`default_nettype none

// Streaming ARMA inverse filter. Each input transaction carries a kind in
// s_tuser: an AR or MA coefficient load (Q4.20) or a restart, each giving no
// result, or a sample (Q16.16). A sample past the warm-up of max(ar_order,
// ma_order) samples, each order capped at its table depth, yields one result
// transaction with the rounded, saturated residual sample - prediction and a
// clip flag in m_tuser. A sample is accepted, then a single 24x32
// multiply-accumulate steps through every slot of both coefficient tables,
// followed by the product register drain, the rounding and the saturation.
// Warm-up samples skip the multiply-accumulate. The result sits in an output
// register, so the next transaction is accepted while it waits; a sample whose
// result is ready stalls only if the previous result has still not been taken.
// Configuration writes are taken at any time and should be made while idle.
module arma_residual_filter_core #(
    parameter int MAX_AR = 20,
    parameter int MAX_MA = 5
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // coef_index [4:0], coef_value [28:5], sample [60:29], zero fill [63:61]
    input  wire logic [arf_pkg::S_TDATA_W-1:0]       s_tdata,
    // kind [1:0]
    input  wire logic [arf_pkg::KIND_W-1:0]          s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // residual [31:0]
    output logic [arf_pkg::M_TDATA_W-1:0]            m_tdata,
    // saturated [0]
    output logic [0:0]                               m_tuser,
    input  wire logic                                cfg_wr_en,
    input  wire logic [arf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [arf_pkg::DATA_W-1:0]          cfg_wdata
);
    import arf_pkg::*;

    localparam int MAXP = (MAX_AR > MAX_MA) ? MAX_AR : MAX_MA;
    localparam int STW  = $clog2(MAXP + 1);

    arf_cmd_t                 cmd;
    arf_status_t              status;
    logic [STW-1:0]           tap_idx;
    logic signed [DATA_W-1:0] residual;
    logic                     saturated;

    arf_ctrl #(
        .MAX_AR (MAX_AR),
        .MAX_MA (MAX_MA),
        .STW    (STW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .tap_idx  (tap_idx)
    );

    arf_datapath #(
        .MAX_AR (MAX_AR),
        .MAX_MA (MAX_MA),
        .STW    (STW)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .tap_idx    (tap_idx),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .coef_index (s_tdata[COEF_IDX_LSB +: IDX_W]),
        .coef_value ($signed(s_tdata[COEF_VAL_LSB +: COEF_W])),
        .sample     ($signed(s_tdata[SAMPLE_LSB +: DATA_W])),
        .status     (status),
        .residual   (residual),
        .saturated  (saturated)
    );

    assign m_tdata    = residual;
    assign m_tuser[0] = saturated;

endmodule

`default_nettype wire

### tb/testbench.sv
// testbench for the streaming arma residual filter core
`timescale 1ns / 100ps

module testbench;
    import arf_pkg::*;

    localparam int N_AR    = 20;
    localparam int N_MA    = 5;
    localparam int SETTLE  = 2 * (N_AR + N_MA + 4);
    localparam int N_PHASE = 8;

    typedef struct packed {
        logic [DATA_W-1:0] residual;
        logic              saturated;
    } residual_t;

    // predicts residuals from accepted input transactions and checks result transactions
    class residual_scoreboard;
        logic [AR_ORDER_W-1:0]    ar_order;
        logic [MA_ORDER_W-1:0]    ma_order;
        logic signed [DATA_W-1:0] intercept;
        logic signed [COEF_W-1:0] ar_coef [N_AR];
        logic signed [COEF_W-1:0] ma_coef [N_MA];
        logic signed [DATA_W-1:0] past_samples [N_AR];
        logic signed [DATA_W-1:0] past_residuals [N_MA];
        int                       series_len;
        residual_t                pending_q [$];
        int                       errors;

        function new();
            ar_order  = '0;
            ma_order  = '0;
            intercept = '0;
            errors    = 0;
            for (int i = 0; i < N_AR; i++) ar_coef[i] = '0;
            for (int i = 0; i < N_MA; i++) ma_coef[i] = '0;
            clear_series();
        endfunction

        function void clear_series();
            for (int i = 0; i < N_AR; i++) past_samples[i] = '0;
            for (int i = 0; i < N_MA; i++) past_residuals[i] = '0;
            series_len = 0;
        endfunction

        function void set_config(logic [AR_ORDER_W-1:0] ar, logic [MA_ORDER_W-1:0] ma,
                                 logic [DATA_W-1:0] ic);
            ar_order  = ar;
            ma_order  = ma;
            intercept = ic;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function void note_input(kind_t k, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] cv,
                                 logic signed [DATA_W-1:0] x);
            int                       p;
            int                       q;
            int                       warm;
            logic signed [ACC_W-1:0]  acc;
            logic signed [ACC_W-1:0]  rounded;
            logic signed [DATA_W-1:0] res;
            logic                     sat;
            residual_t                item;
            case (k)
                KIND_LOAD_AR: begin
                    if (idx < N_AR) ar_coef[idx] = cv;
                end
                KIND_LOAD_MA: begin
                    if (idx < N_MA) ma_coef[idx] = cv;
                end
                KIND_RESTART: begin
                    clear_series();
                end
                default: begin
                    p    = (ar_order > N_AR) ? N_AR : int'(ar_order);
                    q    = (ma_order > N_MA) ? N_MA : int'(ma_order);
                    warm = (p > q) ? p : q;
                    res  = '0;
                    sat  = 1'b0;
                    if (series_len >= warm) begin
                        acc = ACC_W'(intercept);
                        acc = acc <<< FRAC_SHIFT;
                        for (int i = 0; i < p; i++)
                            acc = acc + ACC_W'(ar_coef[i]) * ACC_W'(past_samples[i]);
                        for (int i = 0; i < q; i++)
                            acc = acc + ACC_W'(ma_coef[i]) * ACC_W'(past_residuals[i]);
                        rounded = ACC_W'(x);
                        // round half up, then drop the 20 fraction bits
                        rounded = ((rounded <<< FRAC_SHIFT) - acc + ROUND_HALF) >>> FRAC_SHIFT;
                        if (rounded > 64'sh0000_0000_7FFF_FFFF) begin
                            res = SAT_POS;
                            sat = 1'b1;
                        end else if (rounded < -64'sh0000_0000_8000_0000) begin
                            res = SAT_NEG;
                            sat = 1'b1;
                        end else begin
                            res = rounded[DATA_W-1:0];
                        end
                        item.residual  = res;
                        item.saturated = sat;
                        pending_q = {pending_q, item};
                    end
                    for (int i = N_AR - 1; i > 0; i--) past_samples[i] = past_samples[i-1];
                    past_samples[0] = x;
                    for (int i = N_MA - 1; i > 0; i--) past_residuals[i] = past_residuals[i-1];
                    past_residuals[0] = res;
                    if (series_len < 255) series_len++;
                end
            endcase
        endfunction

        function void check_result(logic [DATA_W-1:0] residual, logic saturated);
            residual_t want;
            if (pending_q.size() == 0) begin
                $error("unexpected result: residual %0d saturated %0d",
                       $signed(residual), saturated);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (residual !== want.residual) begin
                $error("residual: expected %0d, got %0d",
                       $signed(want.residual), $signed(residual));
                errors++;
            end
            if (saturated !== want.saturated) begin
                $error("saturated: expected %0d, got %0d", want.saturated, saturated);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0]     cfg_wdata = '0;

    residual_scoreboard sb;
    bit                 fast_mode = 1'b0;
    bit                 hold_req  = 1'b0;

    arma_residual_filter_core #(
        .MAX_AR(N_AR),
        .MAX_MA(N_MA)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic logic [DATA_W-1:0] rand_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
            1, 2, 3: return r;
            default: return {{8{r[23]}}, r[23:0]};
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
            1, 2: return r[COEF_W-1:0];
            default: return {{5{r[18]}}, r[18:0]};
        endcase
    endfunction

    task automatic send_item(kind_t k, logic [IDX_W-1:0] idx, logic [COEF_W-1:0] cv,
                             logic [DATA_W-1:0] smp);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap = fast_mode ? 0 : $urandom_range(0, 18);
        word = '0;
        word[COEF_IDX_LSB +: IDX_W]  = idx;
        word[COEF_VAL_LSB +: COEF_W] = cv;
        word[SAMPLE_LSB +: DATA_W]   = smp;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= k;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(k, idx, cv, smp);
    endtask

    task automatic send_sample(logic [DATA_W-1:0] smp);
        send_item(KIND_SAMPLE, IDX_W'($urandom), COEF_W'($urandom), smp);
    endtask

    // pause input until every expected result is out, then let the core go quiet
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic configure(logic [AR_ORDER_W-1:0] ar, logic [MA_ORDER_W-1:0] ma,
                             logic [DATA_W-1:0] ic);
        logic [31:0] junk;
        junk = $urandom;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_AR_ORDER;
        cfg_wdata <= {junk[DATA_W-1:AR_ORDER_W], ar};
        @(posedge aclk);
        cfg_index <= CFG_MA_ORDER;
        cfg_wdata <= {junk[DATA_W-1:MA_ORDER_W], ma};
        @(posedge aclk);
        cfg_index <= CFG_INTERCEPT;
        cfg_wdata <= ic;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_config(ar, ma, ic);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = 500;
            end else begin
                gap = fast_mode ? 0 : $urandom_range(0, 18);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    initial begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int                    n_items;
        int                    sel;
        logic [AR_ORDER_W-1:0] ar;
        logic [MA_ORDER_W-1:0] ma;
        logic [DATA_W-1:0]     ic;
        logic [31:0]           r;

        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state: no taps, so the residual is the sample itself
        send_sample(32'h1234_5678);
        drain_block();

        configure(5'd2, 3'd1, 32'hFFFF_FFFF);
        send_item(KIND_LOAD_AR, 5'd0, 24'h7F_FFFF, rand_sample());
        send_item(KIND_LOAD_AR, 5'd1, 24'h80_0000, rand_sample());
        send_item(KIND_LOAD_AR, 5'd19, rand_coef(), rand_sample());
        // slots beyond the tables are dropped
        send_item(KIND_LOAD_AR, 5'd20, 24'h7F_FFFF, rand_sample());
        send_item(KIND_LOAD_AR, 5'd31, 24'h80_0000, rand_sample());
        send_item(KIND_LOAD_MA, 5'd0, 24'h80_0000, rand_sample());
        send_item(KIND_LOAD_MA, 5'd4, 24'h7F_FFFF, rand_sample());
        send_item(KIND_LOAD_MA, 5'd5, 24'h7F_FFFF, rand_sample());
        send_item(KIND_LOAD_MA, 5'd31, 24'h80_0000, rand_sample());
        send_item(KIND_RESTART, 5'd31, 24'hFF_FFFF, 32'hFFFF_FFFF);
        // warm-up of two, then clipping both ways
        send_sample(SAT_POS);
        send_sample(SAT_NEG);
        send_sample(32'h0000_0000);
        send_sample(SAT_POS);
        send_sample(SAT_NEG);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);
        send_item(KIND_RESTART, 5'd0, 24'h00_0000, 32'h0000_0000);
        send_sample(32'h0001_0000);
        drain_block();

        // oversized orders with the series carried over
        configure(5'd31, 3'd7, SAT_NEG);
        send_sample(SAT_POS);
        send_sample(32'h0000_8000);
        send_sample(SAT_NEG);
        drain_block();
        configure(5'd0, 3'd0, SAT_POS);
        send_sample(SAT_NEG);
        send_sample(32'h0000_0002);

        for (int ph = 0; ph < N_PHASE; ph++) begin
            drain_block();
            fast_mode = (ph == 3);
            case ($urandom_range(0, 4))
                0: ar = AR_ORDER_W'($urandom_range(0, 3));
                1: ar = AR_ORDER_W'(N_AR);
                2: ar = AR_ORDER_W'($urandom_range(N_AR + 1, 31));
                default: ar = AR_ORDER_W'($urandom_range(0, N_AR));
            endcase
            ma = MA_ORDER_W'($urandom_range(0, 7));
            r  = $urandom;
            case ($urandom_range(0, 4))
                0: ic = $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
                1: ic = r;
                default: ic = {{10{r[21]}}, r[21:0]};
            endcase
            configure(ar, ma, ic);
            if (ph == 1) hold_req = 1'b1;
            if ($urandom_range(0, 3) != 0)
                send_item(KIND_RESTART, IDX_W'($urandom), COEF_W'($urandom), $urandom);
            if ($urandom_range(0, 4) != 0) begin
                for (int i = 0; i < N_AR; i++)
                    send_item(KIND_LOAD_AR, IDX_W'(i), rand_coef(), $urandom);
                for (int i = 0; i < N_MA; i++)
                    send_item(KIND_LOAD_MA, IDX_W'(i), rand_coef(), $urandom);
            end
            // phase 5 runs one long series past the sample count limit
            n_items = (ph == 5) ? 320 : 160;
            for (int n = 0; n < n_items; n++) begin
                sel = $urandom_range(0, 99);
                if (ph == 5 || sel >= 12)
                    send_sample(rand_sample());
                else if (sel < 3)
                    send_item(KIND_RESTART, IDX_W'($urandom), COEF_W'($urandom), $urandom);
                else if (sel < 9)
                    send_item(KIND_LOAD_AR,
                              IDX_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                               : $urandom_range(0, N_AR - 1)),
                              rand_coef(), $urandom);
                else
                    send_item(KIND_LOAD_MA,
                              IDX_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                               : $urandom_range(0, N_MA - 1)),
                              rand_coef(), $urandom);
            end
        end
        fast_mode = 1'b0;
        drain_block();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/arf_pkg.sv
hw/rtl/arf_ctrl.sv
hw/rtl/arf_datapath.sv
hw/rtl/arma_residual_filter_core.sv
tb/testbench.sv
